[rtl/sfe_pkg.sv]
// Package for the serial frame engine: sizes, request and error codes,
// result word type and byte lookup functions. No dependencies.
`default_nettype none
package sfe_pkg;

    localparam int OUT_DEPTH = 512;
    localparam int IN_DEPTH  = 128;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int IN_AW     = $clog2(IN_DEPTH);
    localparam int FILL_W    = 8;

    localparam logic [3:0] REQ_OPEN   = 4'd0;
    localparam logic [3:0] REQ_APPEND = 4'd1;
    localparam logic [3:0] REQ_CLOSE  = 4'd2;
    localparam logic [3:0] REQ_TXDONE = 4'd3;
    localparam logic [3:0] REQ_RXBYTE = 4'd4;
    localparam logic [3:0] REQ_START_IN  = 4'd5;
    localparam logic [3:0] REQ_START_OUT = 4'd6;
    localparam logic [3:0] REQ_READ   = 4'd7;
    localparam logic [3:0] REQ_TAKE   = 4'd8;

    localparam logic [1:0] MODE_DOWN = 2'd0;
    localparam logic [1:0] MODE_IN   = 2'd1;
    localparam logic [1:0] MODE_OUT  = 2'd2;

    localparam logic [1:0] ERR_OVERFLOW = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [1:0] ERR_SMALL    = 2'd2;
    localparam logic [1:0] ERR_STALE    = 2'd3;

    localparam logic [1:0] KIND_LAST = 2'd2;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_R      = 8'h52;

    localparam logic [3:0] REQ_POS_END = 4'd8;

    localparam logic [7:0] CMD_LETTERS [10] = '{
        8'h52, 8'h42, 8'h54, 8'h55, 8'h53, 8'h45, 8'h4F, 8'h50, 8'h44, 8'h43
    };
    localparam logic [7:0] KIND_LETTERS [3] = '{8'h53, 8'h45, 8'h44};

    typedef struct packed {
        logic                tx_valid;
        logic [7:0]          tx_byte;
        logic                cmd_valid;
        logic [3:0]          cmd_code;
        logic [FILL_W-1:0]   payload_count;
        logic [7:0]          read_data;
        logic                error_valid;
        logic [1:0]          err_code;
        logic [1:0]          link_mode;
    } sfe_result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } sfe_cmd_hit_t;

    function automatic sfe_cmd_hit_t cmd_lookup(input logic [7:0] b);
        sfe_cmd_hit_t r;
        r = '0;
        for (int i = 9; i >= 0; i--) begin
            if (CMD_LETTERS[i] == b) begin
                r.hit  = 1'b1;
                r.code = 4'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] request_byte(input logic [3:0] pos);
        logic [7:0] r;
        if (pos < 4'd3) r = CH_CARET;
        else if (pos == 4'd3) r = CH_R;
        else if (pos == 4'd4) r = 8'(IN_DEPTH);
        else r = CH_DOLLAR;
        return r;
    endfunction

    function automatic logic [7:0] header_byte(input logic [2:0] idx,
                                               input logic [1:0] kind,
                                               input logic [15:0] addr);
        logic [7:0] r;
        case (idx)
            3'd3:    r = KIND_LETTERS[kind];
            3'd4:    r = addr[7:0];
            3'd5:    r = addr[15:8];
            default: r = CH_CARET;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/sfe_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module sfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/sfe_out_slot.sv]
// Output register for result words; parts the sequencer from the taker.
// Depends on sfe_pkg.
`default_nettype none
module sfe_out_slot
    import sfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire sfe_result_t load_data,
    output logic             slot_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output sfe_result_t      out_data
);
    logic valid_reg;
    sfe_result_t data_reg;

    assign slot_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && slot_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && slot_ready)
        begin
            data_reg <= load_data;
        end
    end
endmodule
`default_nettype wire

[rtl/serial_frame_engine_core.sv]
// Top level of the serial frame engine: request sequencer, output ring RAM,
// input store RAM and output slot. Depends on sfe_pkg, sfe_ram, sfe_out_slot.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid / in_ready  | req_type frame_kind byte_in read_index max_bytes
//  result   | out_valid / out_ready| tx_valid tx_byte cmd_valid cmd_code
//           |                      | payload_count read_data error_valid
//           |                      | err_code link_mode
//  config   | cfg_valid / cfg_ready| cfg_data (node address)
//
// Every request gives one result word. A request is latched, worked in S_EXEC
// and loaded into the output slot from S_DONE; a ring or store read passes S_RD
// for the registered RAM read, and a valid frame open, append or close writes
// its ring bytes (6, 1, 3) in S_PUT through the single ring write port. A new
// word is accepted in the cycle its predecessor's result loads into the output
// slot. Reset is asynchronous and clears all control state; RAM contents are
// not cleared. A stalled output holds its word while the next request is worked.
`default_nettype none
module serial_frame_engine_core
    import sfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  req_type,
    input  wire logic [1:0]  frame_kind,
    input  wire logic [7:0]  byte_in,
    input  wire logic [6:0]  read_index,
    input  wire logic [7:0]  max_bytes,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             cmd_valid,
    output logic [3:0]       cmd_code,
    output logic [7:0]       payload_count,
    output logic [7:0]       read_data,
    output logic             error_valid,
    output logic [1:0]       err_code,
    output logic [1:0]       link_mode,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PUT, S_RD, S_DONE} state_t;

    state_t state_reg, state_next;

    // latched request word
    logic [3:0] req_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [6:0] ridx_reg;
    logic [7:0] maxb_reg;

    logic [15:0]       node_addr_reg;
    logic [OUT_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic              pending_reg, pending_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        btc_reg, btc_next;
    logic [7:0]        gotcmd_reg, gotcmd_next;
    logic              await_cmd_reg, await_cmd_next;
    logic              await_len_reg, await_len_next;
    logic [3:0]        rpos_reg, rpos_next;
    logic [1:0]        mode_reg, mode_next;
    logic [2:0]        put_idx_reg, put_idx_next;
    logic [2:0]        put_last_reg, put_last_next;
    logic              rd_ring_reg, rd_ring_next;
    sfe_result_t       res_reg, res_next;

    logic        accept;
    logic        slot_ready;
    logic        slot_load;
    sfe_result_t slot_data;

    logic              ring_we;
    logic [7:0]        ring_wdata;
    logic [7:0]        ring_rdata;
    logic              store_we;
    logic [7:0]        store_rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_DONE && slot_ready);
    assign accept    = in_valid && in_ready;
    assign slot_load = (state_reg == S_DONE);

    function automatic logic [OUT_AW-1:0] ptr_inc(input logic [OUT_AW-1:0] p);
        logic [OUT_AW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s >= (OUT_AW+1)'(OUT_DEPTH)) ? '0 : s[OUT_AW-1:0];
    endfunction

    always_comb
    begin
        logic [FILL_W-1:0] fill_v;
        sfe_cmd_hit_t      hit;
        logic              pend_v;
        logic              take;

        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        pending_next   = pending_reg;
        fill_next      = fill_reg;
        btc_next       = btc_reg;
        gotcmd_next    = gotcmd_reg;
        await_cmd_next = await_cmd_reg;
        await_len_next = await_len_reg;
        rpos_next      = rpos_reg;
        mode_next      = mode_reg;
        put_idx_next   = put_idx_reg;
        put_last_next  = put_last_reg;
        rd_ring_next   = rd_ring_reg;
        res_next       = res_reg;
        ring_we        = 1'b0;
        ring_wdata     = CH_DOLLAR;
        store_we       = 1'b0;
        fill_v         = fill_reg;
        hit            = cmd_lookup(gotcmd_reg);
        pend_v         = pending_reg && (wp_reg != rp_reg);
        take           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                case (req_reg)
                    REQ_OPEN:
                    begin
                        if (kind_reg <= KIND_LAST)
                        begin
                            state_next    = S_PUT;
                            put_idx_next  = 3'd0;
                            put_last_next = 3'd5;
                        end
                    end
                    REQ_APPEND:
                    begin
                        state_next    = S_PUT;
                        put_idx_next  = 3'd0;
                        put_last_next = 3'd0;
                    end
                    REQ_CLOSE:
                    begin
                        state_next    = S_PUT;
                        put_idx_next  = 3'd0;
                        put_last_next = 3'd2;
                    end
                    REQ_TXDONE:
                    begin
                        if (mode_reg == MODE_IN)
                        begin
                            if (rpos_reg < REQ_POS_END)
                            begin
                                rpos_next = rpos_reg + 4'd1;
                                if (rpos_next < REQ_POS_END)
                                begin
                                    res_next.tx_valid = 1'b1;
                                    res_next.tx_byte  = request_byte(rpos_next);
                                end
                                else
                                begin
                                    await_cmd_next = 1'b1;
                                end
                            end
                        end
                        else if (mode_reg == MODE_OUT)
                        begin
                            pending_next = pend_v;
                            if (pend_v)
                            begin
                                rp_next      = ptr_inc(rp_reg);
                                rd_ring_next = 1'b1;
                                state_next   = S_RD;
                            end
                        end
                    end
                    REQ_RXBYTE:
                    begin
                        if (mode_reg == MODE_IN)
                        begin
                            if (await_cmd_reg)
                            begin
                                await_cmd_next = 1'b0;
                                gotcmd_next    = byte_reg;
                                await_len_next = 1'b1;
                            end
                            else if (await_len_reg)
                            begin
                                await_len_next = 1'b0;
                                btc_next       = byte_reg;
                            end
                            else
                            begin
                                store_we = 1'b1;
                                fill_v   = fill_reg + 1'b1;
                                if (fill_v >= FILL_W'(IN_DEPTH))
                                begin
                                    res_next.error_valid = 1'b1;
                                    res_next.err_code    = ERR_OVERFLOW;
                                    fill_v    = '0;
                                    mode_next = MODE_DOWN;
                                end
                                btc_next = btc_reg - 8'd1;
                                if (btc_next == 8'd0)
                                begin
                                    mode_next = MODE_DOWN;
                                    if (fill_v != '0)
                                    begin
                                        if (hit.hit)
                                        begin
                                            res_next.cmd_valid = 1'b1;
                                            res_next.cmd_code  = hit.code;
                                        end
                                        else
                                        begin
                                            res_next.error_valid = 1'b1;
                                            res_next.err_code    = ERR_UNKNOWN;
                                            fill_v = '0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    REQ_START_IN:
                    begin
                        if (fill_reg != '0)
                        begin
                            res_next.error_valid = 1'b1;
                            res_next.err_code    = ERR_STALE;
                            fill_v = '0;
                        end
                        mode_next      = MODE_IN;
                        rpos_next      = 4'd0;
                        await_cmd_next = 1'b0;
                        await_len_next = 1'b0;
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = request_byte(4'd0);
                    end
                    REQ_START_OUT:
                    begin
                        mode_next    = MODE_OUT;
                        pending_next = pend_v;
                        if (pend_v)
                        begin
                            rp_next      = ptr_inc(rp_reg);
                            rd_ring_next = 1'b1;
                            state_next   = S_RD;
                        end
                        else
                        begin
                            mode_next = MODE_DOWN;
                            if (fill_reg != '0)
                            begin
                                if (hit.hit)
                                begin
                                    res_next.cmd_valid = 1'b1;
                                    res_next.cmd_code  = hit.code;
                                end
                                else
                                begin
                                    res_next.error_valid = 1'b1;
                                    res_next.err_code    = ERR_UNKNOWN;
                                    fill_v = '0;
                                end
                            end
                        end
                    end
                    REQ_READ:
                    begin
                        if ({1'b0, ridx_reg} < 8'(IN_DEPTH))
                        begin
                            rd_ring_next = 1'b0;
                            state_next   = S_RD;
                        end
                    end
                    REQ_TAKE:
                    begin
                        take = 1'b1;
                        if (maxb_reg < fill_reg)
                        begin
                            res_next.error_valid = 1'b1;
                            res_next.err_code    = ERR_SMALL;
                            res_next.payload_count = '0;
                        end
                        else
                        begin
                            res_next.payload_count = fill_reg;
                        end
                        fill_v = '0;
                    end
                    default:
                    begin
                    end
                endcase
                fill_next = fill_v;
                if (!take)
                begin
                    res_next.payload_count = fill_v;
                end
                res_next.link_mode = mode_next;
            end
            S_PUT:
            begin
                ring_we = 1'b1;
                if (req_reg == REQ_OPEN)
                begin
                    ring_wdata = header_byte(put_idx_reg, kind_reg, node_addr_reg);
                end
                else if (req_reg == REQ_APPEND)
                begin
                    ring_wdata = byte_reg;
                end
                wp_next      = ptr_inc(wp_reg);
                pending_next = 1'b1;
                put_idx_next = put_idx_reg + 3'd1;
                if (put_idx_reg == put_last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                if (rd_ring_reg)
                begin
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = ring_rdata;
                end
                else
                begin
                    res_next.read_data = store_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_ready)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            node_addr_reg <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            pending_reg   <= 1'b0;
            fill_reg      <= '0;
            btc_reg       <= '0;
            gotcmd_reg    <= '0;
            await_cmd_reg <= 1'b0;
            await_len_reg <= 1'b0;
            rpos_reg      <= '0;
            mode_reg      <= MODE_DOWN;
            put_idx_reg   <= '0;
            put_last_reg  <= '0;
            rd_ring_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            pending_reg   <= pending_next;
            fill_reg      <= fill_next;
            btc_reg       <= btc_next;
            gotcmd_reg    <= gotcmd_next;
            await_cmd_reg <= await_cmd_next;
            await_len_reg <= await_len_next;
            rpos_reg      <= rpos_next;
            mode_reg      <= mode_next;
            put_idx_reg   <= put_idx_next;
            put_last_reg  <= put_last_next;
            rd_ring_reg   <= rd_ring_next;
            if (cfg_valid && cfg_ready)
            begin
                node_addr_reg <= cfg_data;
            end
        end
    end

    // hold the request word and staged result; payload needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            req_reg  <= req_type;
            kind_reg <= frame_kind;
            byte_reg <= byte_in;
            ridx_reg <= read_index;
            maxb_reg <= max_bytes;
        end
    end

    sfe_ram #(.WIDTH(8), .DEPTH(OUT_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (ring_wdata),
        .raddr (rp_reg),
        .rdata (ring_rdata)
    );

    sfe_ram #(.WIDTH(8), .DEPTH(IN_DEPTH)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (fill_reg[IN_AW-1:0]),
        .wdata (byte_reg),
        .raddr (IN_AW'(ridx_reg)),
        .rdata (store_rdata)
    );

    sfe_out_slot u_slot (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (slot_load),
        .load_data  (res_reg),
        .slot_ready (slot_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (slot_data)
    );

    assign tx_valid      = slot_data.tx_valid;
    assign tx_byte       = slot_data.tx_byte;
    assign cmd_valid     = slot_data.cmd_valid;
    assign cmd_code      = slot_data.cmd_code;
    assign payload_count = slot_data.payload_count;
    assign read_data     = slot_data.read_data;
    assign error_valid   = slot_data.error_valid;
    assign err_code      = slot_data.err_code;
    assign link_mode     = slot_data.link_mode;
endmodule
`default_nettype wire

[rtl/sfe_checker.sv]
// Port-level checker for the serial frame engine and its bind to the top.
// Depends on sfe_pkg and serial_frame_engine_core.
`default_nettype none
module sfe_checker
    import sfe_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       tx_valid,
    input wire logic [7:0] tx_byte,
    input wire logic       cmd_valid,
    input wire logic [3:0] cmd_code,
    input wire logic [7:0] payload_count,
    input wire logic       error_valid,
    input wire logic [1:0] err_code,
    input wire logic [1:0] link_mode
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(link_mode))
        else $error("result word changed while stalled");

    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0)
        else $error("tx_byte nonzero without tx_valid");

    a_cmd_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_valid |-> link_mode == MODE_DOWN && payload_count != 8'd0)
        else $error("command decoded while link not stopped");

    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cmd_valid |-> cmd_code == 4'd0)
        else $error("cmd_code nonzero without cmd_valid");

    a_err_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_valid && (err_code == ERR_OVERFLOW || err_code == ERR_UNKNOWN
            || err_code == ERR_STALE) |-> payload_count == 8'd0)
        else $error("input store not emptied on error");
endmodule

bind serial_frame_engine_core sfe_checker u_sfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .cmd_valid     (cmd_valid),
    .cmd_code      (cmd_code),
    .payload_count (payload_count),
    .error_valid   (error_valid),
    .err_code      (err_code),
    .link_mode     (link_mode)
);
`default_nettype wire

[test/serial_frame_engine_core_tb.sv]
// Testbench for serial_frame_engine_core: directed table then random framed
// sessions, checked word by word against a behavioral predictor. Needs sfe_pkg.
`default_nettype none
module serial_frame_engine_core_tb
    import sfe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TOTAL_WORDS    = 1700;
    localparam int QUIET_FROM     = 1500;
    localparam logic [7:0] CMD_CHARS [10] = '{"R", "B", "T", "U", "S", "E", "O", "P", "D", "C"};
    localparam logic [7:0] KIND_CHARS [3] = '{"S", "E", "D"};
    localparam sfe_result_t ZERO_WORD = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  req_type = REQ_TXDONE;
    logic [1:0]  frame_kind = 2'd0;
    logic [7:0]  byte_in = 8'd0;
    logic [6:0]  read_index = 7'd0;
    logic [7:0]  max_bytes = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cmd_valid;
    logic [3:0]  cmd_code;
    logic [7:0]  payload_count;
    logic [7:0]  read_data;
    logic        error_valid;
    logic [1:0]  err_code;
    logic [1:0]  link_mode;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    serial_frame_engine_core dut (.*);

    always #2 clk = ~clk;

    // Predicted state of the link
    logic [15:0] node_addr;
    logic [7:0]  ring_mem [OUT_DEPTH];
    int unsigned ring_wr, ring_rd;
    bit          ring_busy;
    logic [7:0]  in_mem [IN_DEPTH];
    bit          in_written [IN_DEPTH];
    int unsigned in_count;
    logic [7:0]  bytes_left;
    logic [7:0]  cmd_byte;
    bit          want_cmd, want_len;
    int unsigned req_pos;
    logic [1:0]  mode;

    sfe_result_t expected_words [$];
    int          fail_count, word_count, cfg_count, cmd_seen, err_seen;
    int          idle_cycles;
    bit          calm, quiet;
    int          stall_left;

    typedef struct {
        logic [3:0]  req;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [6:0]  idx;
        logic [7:0]  cap;
        bit          typed;
        sfe_result_t want;
    } step_row_t;

    // Directed rows; typed expectations where the answer is obvious
    step_row_t dir_rows [27] = '{
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_OPEN, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_OPEN, 2'd3, 8'h00, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_OPEN, 2'd2, 8'h00, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_APPEND, 2'd0, 8'hFF, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_APPEND, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_CLOSE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1, ZERO_WORD},
        '{REQ_START_OUT, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_START_IN, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1,
          '{tx_valid: 1'b1, tx_byte: CH_CARET, link_mode: MODE_IN, default: '0}},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_TXDONE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_RXBYTE, 2'd0, "B", 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_RXBYTE, 2'd0, 8'd1, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_RXBYTE, 2'd0, 8'hAA, 7'd0, 8'd0, 1'b0, ZERO_WORD},
        '{REQ_READ, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1,
          '{read_data: 8'hAA, payload_count: 8'd1, default: '0}},
        '{REQ_TAKE, 2'd0, 8'h00, 7'd0, 8'd0, 1'b1,
          '{error_valid: 1'b1, err_code: ERR_SMALL, default: '0}},
        '{REQ_TAKE, 2'd0, 8'h00, 7'd0, 8'hFF, 1'b1, ZERO_WORD},
        '{4'd15, 2'd3, 8'hFF, 7'h7F, 8'hFF, 1'b1, ZERO_WORD},
        '{4'd9, 2'd1, 8'h55, 7'h2A, 8'h80, 1'b1, ZERO_WORD}
    };

    function automatic logic [7:0] request_char(int unsigned pos);
        if (pos < 3) return CH_CARET;
        if (pos == 3) return CH_R;
        if (pos == 4) return 8'(IN_DEPTH);
        return CH_DOLLAR;
    endfunction

    function automatic void ring_push(logic [7:0] v);
        ring_mem[ring_wr] = v;
        ring_wr = (ring_wr + 1 >= OUT_DEPTH) ? 0 : ring_wr + 1;
        ring_busy = 1'b1;
    endfunction

    function automatic void ring_pop(inout sfe_result_t r);
        r.tx_valid = 1'b1;
        r.tx_byte = ring_mem[ring_rd];
        ring_rd = (ring_rd + 1 >= OUT_DEPTH) ? 0 : ring_rd + 1;
    endfunction

    function automatic void raise_err(inout sfe_result_t r, input logic [1:0] code);
        r.error_valid = 1'b1;
        r.err_code = code;
    endfunction

    // Drop the link; decode whatever command is stored
    function automatic void stop_link(inout sfe_result_t r);
        mode = MODE_DOWN;
        if (in_count > 0) begin
            for (int i = 0; i < 10; i++) begin
                if (CMD_CHARS[i] == cmd_byte) begin
                    r.cmd_valid = 1'b1;
                    r.cmd_code = 4'(i);
                    return;
                end
            end
            raise_err(r, ERR_UNKNOWN);
            in_count = 0;
        end
    endfunction

    function automatic sfe_result_t link_step(logic [3:0] req, logic [1:0] kind,
                                              logic [7:0] data, logic [6:0] idx,
                                              logic [7:0] cap);
        sfe_result_t r;
        bit handed;
        r = '0;
        handed = 1'b0;
        case (req)
            REQ_OPEN:
                if (kind <= KIND_LAST) begin
                    ring_push(CH_CARET);
                    ring_push(CH_CARET);
                    ring_push(CH_CARET);
                    ring_push(KIND_CHARS[kind]);
                    ring_push(node_addr[7:0]);
                    ring_push(node_addr[15:8]);
                end
            REQ_APPEND: ring_push(data);
            REQ_CLOSE: begin
                ring_push(CH_DOLLAR);
                ring_push(CH_DOLLAR);
                ring_push(CH_DOLLAR);
            end
            REQ_TXDONE:
                if (mode == MODE_IN) begin
                    if (req_pos < 8) begin
                        req_pos++;
                        if (req_pos < 8) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = request_char(req_pos);
                        end else
                            want_cmd = 1'b1;
                    end
                end else if (mode == MODE_OUT) begin
                    if (ring_wr == ring_rd) ring_busy = 1'b0;
                    if (ring_busy) ring_pop(r);
                end
            REQ_RXBYTE:
                if (mode == MODE_IN) begin
                    if (want_cmd) begin
                        want_cmd = 1'b0;
                        cmd_byte = data;
                        want_len = 1'b1;
                    end else if (want_len) begin
                        want_len = 1'b0;
                        bytes_left = data;
                    end else begin
                        if (in_count < IN_DEPTH) begin
                            in_mem[in_count] = data;
                            in_written[in_count] = 1'b1;
                        end
                        in_count++;
                        if (in_count >= IN_DEPTH) begin
                            raise_err(r, ERR_OVERFLOW);
                            in_count = 0;
                            stop_link(r);
                        end
                        bytes_left = bytes_left - 8'd1;
                        if (bytes_left == 8'd0) stop_link(r);
                    end
                end
            REQ_START_IN: begin
                if (in_count > 0) begin
                    raise_err(r, ERR_STALE);
                    in_count = 0;
                end
                mode = MODE_IN;
                req_pos = 0;
                want_cmd = 1'b0;
                want_len = 1'b0;
                r.tx_valid = 1'b1;
                r.tx_byte = request_char(0);
            end
            REQ_START_OUT: begin
                mode = MODE_OUT;
                if (ring_wr == ring_rd) ring_busy = 1'b0;
                if (ring_busy) ring_pop(r);
                else stop_link(r);
            end
            REQ_READ: r.read_data = in_mem[idx];
            REQ_TAKE: begin
                if (cap < in_count) raise_err(r, ERR_SMALL);
                else r.payload_count = 8'(in_count);
                handed = 1'b1;
                in_count = 0;
            end
            default: ;
        endcase
        if (!handed) r.payload_count = 8'(in_count);
        r.link_mode = mode;
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    // Present one word, hold it until accepted, then predict its result
    task automatic send(logic [3:0] req, logic [1:0] kind, logic [7:0] data,
                        logic [6:0] idx, logic [7:0] cap, bit typed = 1'b0,
                        sfe_result_t want = '0);
        sfe_result_t p;
        in_valid <= 1'b1;
        req_type <= req;
        frame_kind <= kind;
        byte_in <= data;
        read_index <= idx;
        max_bytes <= cap;
        do @(posedge clk); while (!in_ready);
        p = link_step(req, kind, data, idx, cap);
        expected_words.push_back(typed ? want : p);
        word_count++;
        if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Hold off until every result is back, then wait with no request presented
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_addr(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_addr = v;
        cfg_count++;
    endtask

    task automatic send_read();
        logic [6:0] idx;
        idx = 7'($urandom);
        for (int t = 0; t < 8 && !in_written[idx]; t++) idx = 7'($urandom);
        if (in_written[idx]) send(REQ_READ, 2'($urandom), 8'($urandom), idx, 8'($urandom));
        else send(REQ_TXDONE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
    endtask

    task automatic noise_word();
        logic [3:0] req;
        req = 4'($urandom_range(0, 15));
        if (req == REQ_READ) send_read();
        else send(req, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
    endtask

    task automatic output_session(int appends);
        send(REQ_OPEN, 2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom), 8'($urandom));
        repeat (appends) send(REQ_APPEND, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) != 0)
            send(REQ_CLOSE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0) return;
        send(REQ_START_OUT, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        while (mode == MODE_OUT && ring_wr != ring_rd)
            send(REQ_TXDONE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 2))
            send(REQ_TXDONE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
    endtask

    task automatic input_session();
        int pick;
        logic [7:0] len;
        send(REQ_START_IN, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        repeat (7 + $urandom_range(0, 2))
            send(REQ_TXDONE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            // broken sequence: something else cuts in
            noise_word();
            return;
        end
        if ($urandom_range(0, 6) != 0)
            send(REQ_RXBYTE, 2'($urandom), CMD_CHARS[$urandom_range(0, 9)], 7'($urandom),
                 8'($urandom));
        else
            send(REQ_RXBYTE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        pick = $urandom_range(0, 24);
        if (pick == 0) len = 8'd0;
        else if (pick == 1) len = 8'($urandom_range(120, 255));
        else len = 8'($urandom_range(1, 12));
        send(REQ_RXBYTE, 2'($urandom), len, 7'($urandom), 8'($urandom));
        while (mode == MODE_IN)
            send(REQ_RXBYTE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 2)) begin
            if (in_count > 0)
                send(REQ_READ, 2'($urandom), 8'($urandom),
                     7'($urandom_range(0, in_count - 1)), 8'($urandom));
        end
        if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 1) == 0)
                send(REQ_TAKE, 2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
            else
                send(REQ_TAKE, 2'($urandom), 8'($urandom), 7'($urandom),
                     8'(in_count + $urandom_range(0, 1)) - 8'($urandom_range(0, 1)));
        end
    endtask

    // Result side: random stall bursts, none in the quiet tail or in calm sessions
    always @(posedge clk) begin
        if (quiet || calm) out_ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else
            out_ready <= 1'b1;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        sfe_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                report("unexpected result word", 1, 0);
            end else begin
                e = expected_words.pop_front();
                if (e.cmd_valid) cmd_seen++;
                if (e.error_valid) err_seen++;
                if (tx_valid !== e.tx_valid) report("tx_valid", tx_valid, e.tx_valid);
                if (tx_byte !== e.tx_byte) report("tx_byte", tx_byte, e.tx_byte);
                if (cmd_valid !== e.cmd_valid) report("cmd_valid", cmd_valid, e.cmd_valid);
                if (cmd_code !== e.cmd_code) report("cmd_code", cmd_code, e.cmd_code);
                if (payload_count !== e.payload_count)
                    report("payload_count", payload_count, e.payload_count);
                if (read_data !== e.read_data) report("read_data", read_data, e.read_data);
                if (error_valid !== e.error_valid)
                    report("error_valid", error_valid, e.error_valid);
                if (err_code !== e.err_code) report("err_code", err_code, e.err_code);
                if (link_mode !== e.link_mode) report("link_mode", link_mode, e.link_mode);
            end
        end
    end

    // Watchdog: too long with no word moving on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int phase;
        logic [15:0] addr_set [5] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h1234};
        node_addr = '0;
        ring_wr = 0;
        ring_rd = 0;
        ring_busy = 1'b0;
        in_count = 0;
        bytes_left = '0;
        cmd_byte = '0;
        want_cmd = 1'b0;
        want_len = 1'b0;
        req_pos = 0;
        mode = MODE_DOWN;
        fail_count = 0;
        word_count = 0;
        cfg_count = 0;
        cmd_seen = 0;
        err_seen = 0;
        idle_cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        quiet = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_addr(16'hA55A);

        foreach (dir_rows[i])
            send(dir_rows[i].req, dir_rows[i].kind, dir_rows[i].data, dir_rows[i].idx,
                 dir_rows[i].cap, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // One long burst of appends to wrap the output ring over unsent bytes
        output_session(520);

        phase = 0;
        while (word_count < TOTAL_WORDS) begin
            if (word_count / 250 > phase && word_count < QUIET_FROM) begin
                phase = word_count / 250;
                drain();
                write_addr(phase < 5 ? addr_set[phase] : 16'($urandom));
            end
            quiet = (word_count >= QUIET_FROM);
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: output_session($urandom_range(0, 8));
                4, 5, 6, 7: input_session();
                8: send_read();
                default: noise_word();
            endcase
        end

        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Covered %0d request words under %0d node addresses;", word_count, cfg_count);
        $display("%0d decoded commands and %0d error codes were predicted.", cmd_seen, err_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
rtl/sfe_pkg.sv
rtl/sfe_ram.sv
rtl/sfe_out_slot.sv
rtl/serial_frame_engine_core.sv
rtl/sfe_checker.sv
test/serial_frame_engine_core_tb.sv
